/* src/cshs_pkg.sv */
`timescale 1ns / 1ps
package cshs_pkg;
    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] MODE_PUSH  = 2'd0;
    localparam logic [1:0] MODE_QUERY = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_SAT      = 3'd1;
    localparam logic [2:0] CAUSE_INVALID  = 3'd2;
    localparam logic [2:0] CAUSE_EXPLICIT = 3'd3;
    localparam logic [2:0] CAUSE_GAP      = 3'd4;

    localparam logic [2:0] ST_BAD_ARG  = 3'd0;
    localparam logic [2:0] ST_MISMATCH = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_INVALID  = 3'd3;
    localparam logic [2:0] ST_SAT      = 3'd4;
    localparam logic [2:0] ST_FUTURE   = 3'd5;
    localparam logic [2:0] ST_STALE    = 3'd6;
    localparam logic [2:0] ST_OK       = 3'd7;

    localparam logic [1:0] REG_OWN_SOURCE = 2'd0;
    localparam logic [1:0] REG_MAX_GAP    = 2'd1;
    localparam logic [1:0] REG_MAX_AGE    = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DEC   = 5'b00100,
        S_READ  = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;
endpackage

/* src/causal_sample_history_store_unit.sv */
`timescale 1ns / 1ps
// A push or query scans all stored entries before its result, unless decided early; a query
// also passes through S_READ. A clear or an early-decided transaction skips the scan, as does
// a push into an empty or just-cleared store.
// Throughput: one transaction at a time, accepted only once the last result has been taken;
// one entry is compared per cycle during the scan, and a full store holds DEPTH = 8 entries.
// Reset (synchronous, aresetn low) empties the store, clears the barrier and loads register
// defaults; no clearing pass is needed.
module causal_sample_history_store_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic        s_sample_present,
    input  logic [1:0]  s_source_id,
    input  logic [63:0] s_time_us,
    input  logic        s_time_trusted,
    input  logic        s_is_saturated,
    input  logic        s_sample_ok,
    input  logic [31:0] s_accel_x,
    input  logic [31:0] s_accel_y,
    input  logic [31:0] s_accel_z,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_ok,
    output logic [2:0]  m_status,
    output logic [63:0] m_out_time_us,
    output logic [31:0] m_out_accel_x,
    output logic [31:0] m_out_accel_y,
    output logic [31:0] m_out_accel_z,
    output logic [63:0] m_age_us
);
    import cshs_pkg::*;

    // Configuration registers.
    logic [1:0]  own_source_reg;
    logic [31:0] max_gap_reg;
    logic [31:0] max_age_reg;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_source_reg <= 2'd0;
            max_gap_reg    <= 32'd10000;
            max_age_reg    <= 32'd10000;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_OWN_SOURCE: own_source_reg <= pwdata[1:0];
                REG_MAX_GAP:    max_gap_reg    <= pwdata;
                REG_MAX_AGE:    max_age_reg    <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_OWN_SOURCE: prdata = {30'd0, own_source_reg};
            REG_MAX_GAP:    prdata = max_gap_reg;
            REG_MAX_AGE:    prdata = max_age_reg;
            default:        prdata = 32'd0;
        endcase
    end

    // Sample store memory.
    logic [63:0] mem_time [DEPTH];
    logic [31:0] mem_ax   [DEPTH];
    logic [31:0] mem_ay   [DEPTH];
    logic [31:0] mem_az   [DEPTH];
    logic [63:0] rd_time_reg;
    logic [31:0] rd_ax_reg, rd_ay_reg, rd_az_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;

    // Transaction and control state.
    state_t      state_reg;
    logic [1:0]  mode_reg;
    logic        present_reg, trusted_reg, sat_reg, sok_reg;
    logic [1:0]  src_reg;
    logic [63:0] t_reg;
    logic [31:0] ax_reg, ay_reg, az_reg;
    logic [CNT_W-1:0] fill_reg;
    logic [63:0] newest_reg;
    logic        newest_known_reg;
    logic [2:0]  cause_reg;
    logic [63:0] barrier_reg;
    logic        barrier_known_reg;
    logic [CNT_W-1:0] i_reg;
    logic        rd_pend_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    // Scan results.
    logic        eq_f_reg, c_f_reg, f_f_reg;
    logic [IDX_W-1:0] eq_i_reg, c_i_reg, f_i_reg, o_i_reg;
    logic [63:0] c_t_reg, f_t_reg, o_t_reg;
    // Push outcome.
    logic        ok_reg;
    logic [2:0]  st_reg;
    logic        emit_reg;
    logic [IDX_W-1:0] emit_i_reg;
    logic        m_valid_reg;
    logic [63:0] age_reg;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;

    // Push pre-checks, evaluated on latched fields.
    logic src_bad, inval, gap_hit;
    assign src_bad = present_reg && (src_reg != own_source_reg);
    assign inval = !present_reg || !trusted_reg || !sok_reg || t_reg == 64'd0
                   || ax_reg[30:23] == 8'hFF || ay_reg[30:23] == 8'hFF
                   || az_reg[30:23] == 8'hFF;
    assign gap_hit = newest_known_reg && t_reg > newest_reg
                     && (t_reg - newest_reg) > {32'd0, max_gap_reg};

    logic [IDX_W-1:0] scan_idx;
    assign scan_idx = rd_idx_reg;
    assign rd_addr  = (state_reg == S_SCAN) ? i_reg[IDX_W-1:0] : emit_i_reg;

    // Memory write and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_time[wr_addr] <= t_reg;
            mem_ax[wr_addr]   <= ax_reg;
            mem_ay[wr_addr]   <= ay_reg;
            mem_az[wr_addr]   <= az_reg;
        end
        rd_time_reg <= mem_time[rd_addr];
        rd_ax_reg   <= mem_ax[rd_addr];
        rd_ay_reg   <= mem_ay[rd_addr];
        rd_az_reg   <= mem_az[rd_addr];
    end

    // Decision logic after the scan.
    logic             full;
    logic [IDX_W-1:0] fill_idx;
    assign full     = (fill_reg == CNT_W'(DEPTH));
    assign fill_idx = fill_reg[IDX_W-1:0];

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = fill_idx;
        if (state_reg == S_DEC && mode_reg == MODE_PUSH && st_reg == ST_OK) begin
            if (eq_f_reg) begin
                wr_en = 1'b1;
                wr_addr = eq_i_reg;
            end else if (!full) begin
                wr_en = 1'b1;
            end else if (t_reg >= o_t_reg) begin
                wr_en = 1'b1;
                wr_addr = o_i_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= S_IDLE;
            m_valid_reg       <= 1'b0;
            fill_reg          <= '0;
            newest_reg        <= 64'd0;
            newest_known_reg  <= 1'b0;
            cause_reg         <= CAUSE_NONE;
            barrier_reg       <= 64'd0;
            barrier_known_reg <= 1'b0;
            i_reg             <= '0;
            rd_pend_reg       <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        mode_reg    <= s_mode;
                        present_reg <= s_sample_present;
                        src_reg     <= s_source_id;
                        t_reg       <= s_time_us;
                        trusted_reg <= s_time_trusted;
                        sat_reg     <= s_is_saturated;
                        sok_reg     <= s_sample_ok;
                        ax_reg      <= s_accel_x;
                        ay_reg      <= s_accel_y;
                        az_reg      <= s_accel_z;
                        i_reg       <= '0;
                        rd_pend_reg <= 1'b0;
                        eq_f_reg    <= 1'b0;
                        c_f_reg     <= 1'b0;
                        f_f_reg     <= 1'b0;
                        emit_reg    <= 1'b0;
                        emit_i_reg  <= '0;
                        age_reg     <= 64'd0;
                        state_reg   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // First cycle handles the early checks; later ones step the scan.
                    if (i_reg == '0 && !rd_pend_reg) begin
                        if (mode_reg == MODE_CLEAR) begin
                            fill_reg          <= '0;
                            newest_reg        <= 64'd0;
                            newest_known_reg  <= 1'b0;
                            cause_reg         <= CAUSE_EXPLICIT;
                            barrier_reg       <= 64'd0;
                            barrier_known_reg <= 1'b0;
                            ok_reg            <= 1'b1;
                            st_reg            <= ST_BAD_ARG;
                            state_reg         <= S_OUT;
                        end else if (mode_reg == MODE_QUERY) begin
                            if (t_reg == 64'd0) begin
                                ok_reg    <= 1'b0;
                                st_reg    <= ST_BAD_ARG;
                                state_reg <= S_OUT;
                            end else if (src_reg != own_source_reg) begin
                                ok_reg    <= 1'b1;
                                st_reg    <= ST_MISMATCH;
                                state_reg <= S_OUT;
                            end else if (fill_reg == '0) begin
                                ok_reg <= 1'b1;
                                if (cause_reg == CAUSE_SAT) begin
                                    st_reg <= ST_SAT;
                                end else if (cause_reg == CAUSE_INVALID
                                             || cause_reg == CAUSE_EXPLICIT
                                             || cause_reg == CAUSE_GAP) begin
                                    st_reg <= ST_INVALID;
                                end else begin
                                    st_reg <= ST_EMPTY;
                                end
                                state_reg <= S_OUT;
                            end else begin
                                rd_pend_reg <= 1'b1;
                                rd_idx_reg  <= '0;
                                i_reg       <= CNT_W'(1);
                            end
                        end else if (mode_reg == MODE_PUSH) begin
                            ok_reg <= 1'b0;
                            if (src_bad) begin
                                st_reg    <= ST_BAD_ARG;
                                state_reg <= S_OUT;
                            end else if (sat_reg || inval) begin
                                st_reg           <= ST_BAD_ARG;
                                fill_reg         <= '0;
                                newest_reg       <= 64'd0;
                                newest_known_reg <= 1'b0;
                                cause_reg        <= sat_reg ? CAUSE_SAT : CAUSE_INVALID;
                                barrier_reg      <= present_reg ? t_reg : 64'd0;
                                barrier_known_reg <= present_reg && t_reg != 64'd0;
                                state_reg        <= S_OUT;
                            end else if (barrier_known_reg && t_reg <= barrier_reg) begin
                                st_reg    <= ST_BAD_ARG;
                                state_reg <= S_OUT;
                            end else begin
                                st_reg <= ST_OK;
                                if (gap_hit) begin
                                    fill_reg          <= '0;
                                    newest_reg        <= 64'd0;
                                    newest_known_reg  <= 1'b0;
                                    cause_reg         <= CAUSE_GAP;
                                    barrier_reg       <= newest_reg;
                                    barrier_known_reg <= newest_reg != 64'd0;
                                    state_reg         <= S_DEC;
                                end else if (fill_reg == '0) begin
                                    state_reg <= S_DEC;
                                end else begin
                                    rd_pend_reg <= 1'b1;
                                    rd_idx_reg  <= '0;
                                    i_reg       <= CNT_W'(1);
                                end
                            end
                        end else begin
                            ok_reg    <= 1'b0;
                            st_reg    <= ST_BAD_ARG;
                            state_reg <= S_OUT;
                        end
                    end else begin
                        // Compare the entry read last cycle.
                        if (rd_time_reg == t_reg && !eq_f_reg) begin
                            eq_f_reg <= 1'b1;
                            eq_i_reg <= scan_idx;
                        end
                        if (scan_idx == '0 || rd_time_reg < o_t_reg) begin
                            o_t_reg <= rd_time_reg;
                            o_i_reg <= scan_idx;
                        end
                        if (rd_time_reg <= t_reg) begin
                            if (!c_f_reg || rd_time_reg > c_t_reg) begin
                                c_f_reg <= 1'b1;
                                c_t_reg <= rd_time_reg;
                                c_i_reg <= scan_idx;
                            end
                        end else if (!f_f_reg || rd_time_reg < f_t_reg) begin
                            f_f_reg <= 1'b1;
                            f_t_reg <= rd_time_reg;
                            f_i_reg <= scan_idx;
                        end
                        if (i_reg == fill_reg) begin
                            rd_pend_reg <= 1'b0;
                            state_reg   <= S_DEC;
                        end else begin
                            rd_idx_reg <= i_reg[IDX_W-1:0];
                            i_reg      <= i_reg + CNT_W'(1);
                        end
                    end
                end
                S_DEC: begin
                    if (mode_reg == MODE_QUERY) begin
                        ok_reg <= 1'b1;
                        if (!c_f_reg) begin
                            st_reg     <= ST_FUTURE;
                            emit_reg   <= f_f_reg;
                            emit_i_reg <= f_i_reg;
                        end else begin
                            age_reg    <= t_reg - c_t_reg;
                            st_reg     <= ((t_reg - c_t_reg) > {32'd0, max_age_reg})
                                          ? ST_STALE : ST_OK;
                            emit_reg   <= 1'b1;
                            emit_i_reg <= c_i_reg;
                        end
                        state_reg <= S_READ;
                    end else begin
                        // Push commit.
                        st_reg <= ST_BAD_ARG;
                        if (wr_en) begin
                            ok_reg <= 1'b1;
                            if (!eq_f_reg) begin
                                if (!full) begin
                                    fill_reg <= fill_reg + CNT_W'(1);
                                end
                                if (!newest_known_reg || t_reg > newest_reg) begin
                                    newest_reg       <= t_reg;
                                    newest_known_reg <= 1'b1;
                                end
                            end
                            cause_reg         <= CAUSE_NONE;
                            barrier_known_reg <= 1'b0;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_READ: begin
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    m_ok          <= ok_reg;
                    m_status      <= st_reg;
                    m_age_us      <= age_reg;
                    m_out_time_us <= emit_reg ? rd_time_reg : 64'd0;
                    m_out_accel_x <= emit_reg ? rd_ax_reg : 32'd0;
                    m_out_accel_y <= emit_reg ? rd_ay_reg : 32'd0;
                    m_out_accel_z <= emit_reg ? rd_az_reg : 32'd0;
                    m_valid_reg   <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end
endmodule
